// ===== rtl/cnc_motion_interpolator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motion interpolator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CNC_MOTION_INTERPOLATOR_CORE_ASSERT_SVH
`define CNC_MOTION_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CMI_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define CMI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMI_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define CMI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/cmi_pkg.sv =====
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared types, codes and constant tables of the motion interpolator.
// ----------------------------------------------------------------------------
package cmi_pkg;

    localparam int COORD_W = 32;
    localparam int CW      = 36;
    localparam int ZW      = 34;
    localparam int SEG_W   = 7;
    localparam int DIV_W   = 40;

    localparam logic [28:0] GAIN_SQ_Q30 = 29'd395948877;

    localparam logic [2:0] ACT_RAPID  = 3'd0;
    localparam logic [2:0] ACT_LINEAR = 3'd1;
    localparam logic [2:0] ACT_CW     = 3'd2;
    localparam logic [2:0] ACT_CCW    = 3'd3;
    localparam logic [2:0] ACT_HOME   = 3'd4;

    localparam logic [1:0] PLANE_YZ = 2'd1;
    localparam logic [1:0] PLANE_XZ = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] REG_WORK_PLANE = 2'd0;
    localparam logic [1:0] REG_ARC_SEGS   = 2'd1;
    localparam logic [1:0] REG_LINE_SEGS  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    localparam logic [SEG_W-1:0] ARC_SEG_RESET  = 7'd50;
    localparam logic [SEG_W-1:0] LINE_SEG_RESET = 7'd5;

    typedef enum logic [2:0] {
        CMD_RAPID,
        CMD_LINEAR,
        CMD_ARC_CW,
        CMD_ARC_CCW,
        CMD_HOME,
        CMD_MISSING,
        CMD_UNSUP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [SEG_W-1:0]           n;
        logic [2:0]                 pres;
        logic signed [COORD_W-1:0]  tx;
        logic signed [COORD_W-1:0]  ty;
        logic signed [COORD_W-1:0]  tz;
        logic signed [COORD_W-1:0]  ci;
        logic signed [COORD_W-1:0]  cj;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_VEC_GO,
        BK_VEC_WAIT,
        BK_GAIN_HI,
        BK_GAIN_LO,
        BK_ANG_MUL,
        BK_ANG_DIV_GO,
        BK_ANG_DIV_WAIT,
        BK_ROT_GO,
        BK_ROT_WAIT,
        BK_LERP_MUL,
        BK_LERP_DIV_GO,
        BK_LERP_DIV_WAIT,
        BK_EMIT
    } bk_state_t;

    // Arctangent of 2^-i as a fraction of a full turn (2^32 = one turn).
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // First arc axis of the plane; plane code 3 behaves as XY.
    function automatic logic [1:0] plane_a(input logic [1:0] p);
        return (p == PLANE_YZ) ? AXIS_Y : AXIS_X;
    endfunction

    function automatic logic [1:0] plane_b(input logic [1:0] p);
        return ((p == PLANE_YZ) || (p == PLANE_XZ)) ? AXIS_Z : AXIS_Y;
    endfunction

    function automatic logic [1:0] plane_c(input logic [1:0] p);
        logic [1:0] c;
        case (p)
            PLANE_YZ: c = AXIS_X;
            PLANE_XZ: c = AXIS_Y;
            default:  c = AXIS_Z;
        endcase
        return c;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick3(
        input logic [1:0]                idx,
        input logic signed [COORD_W-1:0] v0,
        input logic signed [COORD_W-1:0] v1,
        input logic signed [COORD_W-1:0] v2
    );
        logic signed [COORD_W-1:0] r;
        case (idx)
            AXIS_X:  r = v0;
            AXIS_Y:  r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    function automatic logic [SEG_W-1:0] clamp_seg(
        input logic [SEG_W-1:0] v,
        input logic [SEG_W-1:0] lo,
        input logic [SEG_W-1:0] hi
    );
        logic [SEG_W-1:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

// ===== rtl/cnc_motion_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// cnc_motion_interpolator_core
// Turns motion requests into runs of tool positions in Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage. Requests enter on in_valid/in_ready with one port per field; points
// leave on out_valid/out_ready, the final point of a run marked by last. The
// configuration port sets the work plane and the segment counts. The user must
// write it only while the block is idle; the block itself does not enforce
// this. A two-entry queue takes up to two requests while the sequencer is
// still busy with a third. Rapid, home and rejected requests need no
// arithmetic units. A linear point is set by the bit-serial divider, which runs
// once per axis. An arc point takes one CORDIC rotation pass and two divisions,
// after two CORDIC vectoring passes at the start of the arc.
// Reset puts the tool at the origin, selects the XY plane, 50 arc points and
// 5 line points, and empties the queue. When the receiver stalls, the point
// waits in the output register, the sequencer holds, and the queue keeps
// taking requests until it is full.
// ----------------------------------------------------------------------------
module cnc_motion_interpolator_core import cmi_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 24,
    parameter int MAX_SEGMENTS      = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [SEG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  action,
    input  logic signed [COORD_W-1:0]   target_x,
    input  logic signed [COORD_W-1:0]   target_y,
    input  logic signed [COORD_W-1:0]   target_z,
    input  logic [2:0]                  axis_present,
    input  logic signed [COORD_W-1:0]   center_i,
    input  logic signed [COORD_W-1:0]   center_j,
    input  logic [1:0]                  center_present,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_W-1:0]   pos_x,
    output logic signed [COORD_W-1:0]   pos_y,
    output logic signed [COORD_W-1:0]   pos_z,
    output logic                        last,
    output logic [1:0]                  status
);

    logic [1:0]         work_plane_reg;
    logic [SEG_W-1:0]   arc_seg_reg, line_seg_reg;
    cmd_t               front_cmd, head_cmd;
    logic               q_full, q_not_empty, q_pop;

    // Configuration registers; writes to an index beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_plane_reg <= 2'd0;
            arc_seg_reg    <= ARC_SEG_RESET;
            line_seg_reg   <= LINE_SEG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WORK_PLANE: work_plane_reg <= cfg_data[1:0];
                REG_ARC_SEGS:   arc_seg_reg    <= cfg_data;
                REG_LINE_SEGS:  line_seg_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The classifier resolves the request kind and its point count up front.
    cmi_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .action         (action),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_z       (target_z),
        .axis_present   (axis_present),
        .center_i       (center_i),
        .center_j       (center_j),
        .center_present (center_present),
        .work_plane     (work_plane_reg),
        .arc_segments   (arc_seg_reg),
        .line_segments  (line_seg_reg),
        .cmd            (front_cmd)
    );

    assign in_ready = ~q_full;

    cmi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid & ~q_full),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // The sequencer owns the tool position and the output register.
    cmi_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_ready    (q_pop),
        .q_cmd      (head_cmd),
        .work_plane (work_plane_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .last       (last),
        .status     (status)
    );

endmodule

// ===== rtl/cmi_div.sv =====
// ----------------------------------------------------------------------------
// cmi_div
// Restoring unsigned divider by a small segment count, one bit per cycle.
// ----------------------------------------------------------------------------
module cmi_div import cmi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [SEG_W-1:0]    divisor,
    output logic                done,
    output logic [DIV_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [SEG_W-1:0]   rem_reg, rem_next;
    logic [SEG_W-1:0]   dvs_reg, dvs_next;
    logic [SEG_W:0]     trial;
    logic               ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SEG_W'(trial - {1'b0, dvs_reg}) : trial[SEG_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/cmi_cordic.sv =====
// ----------------------------------------------------------------------------
// cmi_cordic
// Iterative CORDIC, one micro-rotation per cycle, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module cmi_cordic import cmi_pkg::*; #(
    parameter int ITERATIONS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    rot,
    input  logic signed [CW-1:0]    x_in,
    input  logic signed [CW-1:0]    y_in,
    input  logic [31:0]             z_in,
    output logic                    done,
    output logic signed [CW-1:0]    x_out,
    output logic signed [CW-1:0]    y_out,
    output logic [31:0]             z_out
);

    localparam int IW = $clog2(ITERATIONS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [IW-1:0]          it_reg, it_next;
    logic                   rot_reg, rot_next;
    logic                   neg_reg, neg_next;
    logic signed [CW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]   z_reg, z_next;
    logic signed [CW-1:0]   xs, ys;
    logic signed [ZW-1:0]   at;
    logic [31:0]            ang, ang_q;
    logic                   plus;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        rot_next  = rot_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        at        = $signed(ZW'(atan_turn(5'(it_reg))));
        plus      = rot_reg ? (z_reg < 0) : (y_reg > 0);
        ang_q     = z_in + 32'h4000_0000;
        ang       = ang_q[31] ? (z_in + 32'h8000_0000) : z_in;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            rot_next  = rot;
            if (rot)
            begin
                // Fold the angle into the right half plane and flip the result.
                neg_next = ang_q[31];
                x_next   = x_in;
                y_next   = y_in;
                z_next   = ZW'($signed(ang));
            end
            else
            begin
                neg_next = 1'b0;
                if (x_in < 0)
                begin
                    x_next = -x_in;
                    y_next = -y_in;
                    z_next = $signed(ZW'(32'h8000_0000));
                end
                else
                begin
                    x_next = x_in;
                    y_next = y_in;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (plus)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IW'(ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign done  = done_reg;
    assign x_out = neg_reg ? -x_reg : x_reg;
    assign y_out = neg_reg ? -y_reg : y_reg;
    assign z_out = z_reg[31:0];

endmodule

// ===== rtl/cmi_back.sv =====
// ----------------------------------------------------------------------------
// cmi_back
// Execution sequencer: holds the tool position and emits the points of a move.
// ----------------------------------------------------------------------------
module cmi_back import cmi_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  cmd_t                        q_cmd,
    input  logic [1:0]                  work_plane,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_W-1:0]   pos_x,
    output logic signed [COORD_W-1:0]   pos_y,
    output logic signed [COORD_W-1:0]   pos_z,
    output logic                        last,
    output logic [1:0]                  status
);

`include "cnc_motion_interpolator_core_assert.svh"

    bk_state_t                  state_reg, state_next;
    cmd_kind_t                  kind_reg, kind_next;
    logic [SEG_W-1:0]           n_reg, n_next, k_reg, k_next;
    logic [1:0]                 axis_reg, axis_next;
    logic                       vec_sel_reg, vec_sel_next;
    logic signed [COORD_W-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0]  cur_z_reg, cur_z_next;
    logic signed [COORD_W-1:0]  tg_x_reg, tg_x_next, tg_y_reg, tg_y_next;
    logic signed [COORD_W-1:0]  tg_z_reg, tg_z_next;
    logic signed [COORD_W-1:0]  pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic signed [COORD_W-1:0]  pt_z_reg, pt_z_next;
    logic signed [COORD_W-1:0]  ci_reg, ci_next, cj_reg, cj_next;
    logic                       last_pt_reg, last_pt_next;
    logic [1:0]                 st_pt_reg, st_pt_next;
    logic [31:0]                sa_reg, sa_next, ang_reg, ang_next;
    logic [32:0]                sweep_reg, sweep_next;
    logic signed [CW-1:0]       amp_reg, amp_next;
    logic [44:0]                gain_hi_reg, gain_hi_next;
    logic [DIV_W-1:0]           prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [COORD_W-1:0]  pos_x_next, pos_y_next, pos_z_next;
    logic                       last_reg, last_next;
    logic [1:0]                 status_reg, status_next;

    // Arithmetic units
    logic                       dv_start, dv_done;
    logic [DIV_W-1:0]           dv_q;
    logic                       cd_start, cd_rot, cd_done;
    logic signed [CW-1:0]       cd_x, cd_y, cd_xo, cd_yo;
    logic [31:0]                cd_zo;

    logic [1:0]                 ia, ib, ic;
    logic                       is_arc, is_ccw;
    logic signed [COORD_W-1:0]  sel_a, sel_b, cur_k, tg_k;
    logic signed [COORD_W-1:0]  tx, ty, tz, pa, pb, pv, qs;
    logic signed [COORD_W:0]    diff;
    logic signed [DIV_W-1:0]    prod_s;
    logic [31:0]                ea, sw, qlow;
    logic [48:0]                lo_prod;
    logic [44:0]                gsum;

    cmi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (neg_reg ? (~prod_reg + 1'b1) : prod_reg),
        .divisor  (n_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    cmi_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .rot   (cd_rot),
        .x_in  (cd_x),
        .y_in  (cd_y),
        .z_in  (ang_reg),
        .done  (cd_done),
        .x_out (cd_xo),
        .y_out (cd_yo),
        .z_out (cd_zo)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        axis_next      = axis_reg;
        vec_sel_next   = vec_sel_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_z_next     = cur_z_reg;
        tg_x_next      = tg_x_reg;
        tg_y_next      = tg_y_reg;
        tg_z_next      = tg_z_reg;
        pt_x_next      = pt_x_reg;
        pt_y_next      = pt_y_reg;
        pt_z_next      = pt_z_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        last_pt_next   = last_pt_reg;
        st_pt_next     = st_pt_reg;
        sa_next        = sa_reg;
        ang_next       = ang_reg;
        sweep_next     = sweep_reg;
        amp_next       = amp_reg;
        gain_hi_next   = gain_hi_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        q_ready        = 1'b0;
        dv_start       = 1'b0;
        cd_start       = 1'b0;
        cd_rot         = 1'b0;

        ia     = plane_a(work_plane);
        ib     = plane_b(work_plane);
        ic     = plane_c(work_plane);
        is_arc = (kind_reg == CMD_ARC_CW) || (kind_reg == CMD_ARC_CCW);
        is_ccw = (kind_reg == CMD_ARC_CCW);

        // Vectoring runs first on the start point, then on the end point.
        sel_a = vec_sel_reg ? pick3(ia, tg_x_reg, tg_y_reg, tg_z_reg)
                            : pick3(ia, cur_x_reg, cur_y_reg, cur_z_reg);
        sel_b = vec_sel_reg ? pick3(ib, tg_x_reg, tg_y_reg, tg_z_reg)
                            : pick3(ib, cur_x_reg, cur_y_reg, cur_z_reg);
        cd_x  = CW'(sel_a) - CW'(ci_reg);
        cd_y  = CW'(sel_b) - CW'(cj_reg);
        if (state_reg == BK_ROT_GO)
        begin
            cd_x = amp_reg;
            cd_y = '0;
        end

        cur_k   = pick3(axis_reg, cur_x_reg, cur_y_reg, cur_z_reg);
        tg_k    = pick3(axis_reg, tg_x_reg, tg_y_reg, tg_z_reg);
        diff    = (COORD_W + 1)'(tg_k) - (COORD_W + 1)'(cur_k);
        prod_s  = DIV_W'(diff) * $signed({{(DIV_W - SEG_W){1'b0}}, k_reg});
        qlow    = dv_q[31:0];
        qs      = neg_reg ? -$signed(qlow) : $signed(qlow);
        pv      = cur_k + qs;
        pa      = ci_reg + cd_xo[COORD_W-1:0];
        pb      = cj_reg + cd_yo[COORD_W-1:0];
        ea      = cd_zo;
        sw      = is_ccw ? (ea - sa_reg) : (sa_reg - ea);
        lo_prod = {29'd0, amp_reg[19:0]} * {20'd0, GAIN_SQ_Q30};
        gsum    = gain_hi_reg + 45'(lo_prod >> 20);

        tx = q_cmd.pres[0] ? q_cmd.tx : cur_x_reg;
        ty = q_cmd.pres[1] ? q_cmd.ty : cur_y_reg;
        tz = q_cmd.pres[2] ? q_cmd.tz : cur_z_reg;

        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    kind_next    = q_cmd.kind;
                    n_next       = q_cmd.n;
                    ci_next      = q_cmd.ci;
                    cj_next      = q_cmd.cj;
                    k_next       = 7'd1;
                    axis_next    = AXIS_X;
                    vec_sel_next = 1'b0;
                    tg_x_next    = tx;
                    tg_y_next    = ty;
                    tg_z_next    = tz;
                    pt_x_next    = tx;
                    pt_y_next    = ty;
                    pt_z_next    = tz;
                    st_pt_next   = ST_OK;
                    last_pt_next = 1'b1;
                    state_next   = BK_EMIT;
                    case (q_cmd.kind)
                        CMD_RAPID:
                        begin
                        end
                        CMD_HOME:
                        begin
                            last_pt_next = 1'b0;
                        end
                        CMD_LINEAR:
                        begin
                            if (q_cmd.n != 7'd1)
                            begin
                                last_pt_next = 1'b0;
                                state_next   = BK_LERP_MUL;
                            end
                        end
                        CMD_ARC_CW, CMD_ARC_CCW:
                        begin
                            last_pt_next = 1'b0;
                            state_next   = BK_VEC_GO;
                        end
                        CMD_MISSING:
                        begin
                            pt_x_next  = cur_x_reg;
                            pt_y_next  = cur_y_reg;
                            pt_z_next  = cur_z_reg;
                            st_pt_next = ST_MISSING;
                        end
                        default:
                        begin
                            pt_x_next  = cur_x_reg;
                            pt_y_next  = cur_y_reg;
                            pt_z_next  = cur_z_reg;
                            st_pt_next = ST_UNSUP;
                        end
                    endcase
                end
            end
            BK_VEC_GO:
            begin
                cd_start   = 1'b1;
                state_next = BK_VEC_WAIT;
            end
            BK_VEC_WAIT:
            begin
                if (cd_done)
                begin
                    if (!vec_sel_reg)
                    begin
                        sa_next      = cd_zo;
                        amp_next     = (cd_xo < 0) ? '0 : cd_xo;
                        vec_sel_next = 1'b1;
                        state_next   = BK_VEC_GO;
                    end
                    else
                    begin
                        // Equal start and end angles sweep a full turn.
                        sweep_next = (sw == 32'd0) ? {1'b1, 32'd0} : {1'b0, sw};
                        state_next = BK_GAIN_HI;
                    end
                end
            end
            BK_GAIN_HI:
            begin
                gain_hi_next = {29'd0, amp_reg[CW-1:20]} * {16'd0, GAIN_SQ_Q30};
                state_next   = BK_GAIN_LO;
            end
            BK_GAIN_LO:
            begin
                amp_next   = $signed(CW'(gsum >> 10));
                state_next = BK_ANG_MUL;
            end
            BK_ANG_MUL:
            begin
                prod_next  = DIV_W'(sweep_reg) * DIV_W'(k_reg);
                neg_next   = 1'b0;
                state_next = BK_ANG_DIV_GO;
            end
            BK_ANG_DIV_GO:
            begin
                dv_start   = 1'b1;
                state_next = BK_ANG_DIV_WAIT;
            end
            BK_ANG_DIV_WAIT:
            begin
                if (dv_done)
                begin
                    ang_next   = is_ccw ? (sa_reg + qlow) : (sa_reg - qlow);
                    state_next = BK_ROT_GO;
                end
            end
            BK_ROT_GO:
            begin
                cd_start   = 1'b1;
                cd_rot     = 1'b1;
                state_next = BK_ROT_WAIT;
            end
            BK_ROT_WAIT:
            begin
                if (cd_done)
                begin
                    case (ia)
                        AXIS_X:  pt_x_next = pa;
                        AXIS_Y:  pt_y_next = pa;
                        default: pt_z_next = pa;
                    endcase
                    case (ib)
                        AXIS_X:  pt_x_next = pb;
                        AXIS_Y:  pt_y_next = pb;
                        default: pt_z_next = pb;
                    endcase
                    axis_next  = ic;
                    state_next = BK_LERP_MUL;
                end
            end
            BK_LERP_MUL:
            begin
                prod_next  = prod_s;
                neg_next   = prod_s[DIV_W-1];
                state_next = BK_LERP_DIV_GO;
            end
            BK_LERP_DIV_GO:
            begin
                dv_start   = 1'b1;
                state_next = BK_LERP_DIV_WAIT;
            end
            BK_LERP_DIV_WAIT:
            begin
                if (dv_done)
                begin
                    case (axis_reg)
                        AXIS_X:  pt_x_next = pv;
                        AXIS_Y:  pt_y_next = pv;
                        default: pt_z_next = pv;
                    endcase
                    if (is_arc || (axis_reg == AXIS_Z))
                    begin
                        state_next = BK_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = BK_LERP_MUL;
                    end
                end
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pos_x_next     = pt_x_reg;
                    pos_y_next     = pt_y_reg;
                    pos_z_next     = pt_z_reg;
                    last_next      = last_pt_reg;
                    status_next    = st_pt_reg;
                    if (last_pt_reg)
                    begin
                        if (st_pt_reg == ST_OK)
                        begin
                            cur_x_next = tg_x_reg;
                            cur_y_next = tg_y_reg;
                            cur_z_next = tg_z_reg;
                        end
                        state_next = BK_IDLE;
                    end
                    else if (kind_reg == CMD_HOME)
                    begin
                        tg_x_next    = '0;
                        tg_y_next    = '0;
                        tg_z_next    = '0;
                        pt_x_next    = '0;
                        pt_y_next    = '0;
                        pt_z_next    = '0;
                        last_pt_next = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        if ((k_reg + 1'b1) == n_reg)
                        begin
                            pt_x_next    = tg_x_reg;
                            pt_y_next    = tg_y_reg;
                            pt_z_next    = tg_z_reg;
                            last_pt_next = 1'b1;
                        end
                        else if (is_arc)
                        begin
                            state_next = BK_ANG_MUL;
                        end
                        else
                        begin
                            axis_next  = AXIS_X;
                            state_next = BK_LERP_MUL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_z_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_z_reg     <= cur_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        axis_reg    <= axis_next;
        vec_sel_reg <= vec_sel_next;
        tg_x_reg    <= tg_x_next;
        tg_y_reg    <= tg_y_next;
        tg_z_reg    <= tg_z_next;
        pt_x_reg    <= pt_x_next;
        pt_y_reg    <= pt_y_next;
        pt_z_reg    <= pt_z_next;
        ci_reg      <= ci_next;
        cj_reg      <= cj_next;
        last_pt_reg <= last_pt_next;
        st_pt_reg   <= st_pt_next;
        sa_reg      <= sa_next;
        ang_reg     <= ang_next;
        sweep_reg   <= sweep_next;
        amp_reg     <= amp_next;
        gain_hi_reg <= gain_hi_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        pos_z_reg   <= pos_z_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    `CMI_ASSERT_IMPL(a_div_done, clk, rst_n, dv_done, (state_reg == BK_ANG_DIV_WAIT) || (state_reg == BK_LERP_DIV_WAIT), "divider done outside wait")
    `CMI_ASSERT_IMPL(a_cordic_done, clk, rst_n, cd_done, (state_reg == BK_VEC_WAIT) || (state_reg == BK_ROT_WAIT), "cordic done outside wait")
    `CMI_ASSERT_IMPL(a_k_range, clk, rst_n, (state_reg == BK_LERP_MUL) || (state_reg == BK_ANG_MUL), (k_reg < n_reg) && (k_reg != 7'd0), "step index out of range")
    `CMI_ASSERT_NEXT(a_last_idle, clk, rst_n, (state_reg == BK_EMIT) && last_pt_reg && (!out_valid_reg || out_ready), (state_reg == BK_IDLE) && out_valid_reg && last_reg, "final point not closing")

endmodule

// ===== rtl/cmi_front.sv =====
// ----------------------------------------------------------------------------
// cmi_front
// Classifies an incoming motion request and settles its point count.
// ----------------------------------------------------------------------------
module cmi_front import cmi_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic [2:0]                  action,
    input  logic signed [COORD_W-1:0]   target_x,
    input  logic signed [COORD_W-1:0]   target_y,
    input  logic signed [COORD_W-1:0]   target_z,
    input  logic [2:0]                  axis_present,
    input  logic signed [COORD_W-1:0]   center_i,
    input  logic signed [COORD_W-1:0]   center_j,
    input  logic [1:0]                  center_present,
    input  logic [1:0]                  work_plane,
    input  logic [SEG_W-1:0]            arc_segments,
    input  logic [SEG_W-1:0]            line_segments,
    output cmd_t                        cmd
);

    logic arc_ok;

    always_comb
    begin
        arc_ok = axis_present[plane_a(work_plane)] && axis_present[plane_b(work_plane)]
                 && (center_present == 2'b11);
        cmd.tx   = target_x;
        cmd.ty   = target_y;
        cmd.tz   = target_z;
        cmd.ci   = center_i;
        cmd.cj   = center_j;
        cmd.pres = axis_present;
        cmd.n    = 7'd1;
        case (action)
            ACT_RAPID:
            begin
                cmd.kind = CMD_RAPID;
            end
            ACT_LINEAR:
            begin
                cmd.kind = CMD_LINEAR;
                cmd.n    = clamp_seg(line_segments, 7'd1, SEG_W'(MAX_SEGMENTS));
            end
            ACT_CW:
            begin
                cmd.kind = arc_ok ? CMD_ARC_CW : CMD_MISSING;
                cmd.n    = clamp_seg(arc_segments, 7'd2, SEG_W'(MAX_SEGMENTS));
            end
            ACT_CCW:
            begin
                cmd.kind = arc_ok ? CMD_ARC_CCW : CMD_MISSING;
                cmd.n    = clamp_seg(arc_segments, 7'd2, SEG_W'(MAX_SEGMENTS));
            end
            ACT_HOME:
            begin
                cmd.kind = CMD_HOME;
                cmd.n    = 7'd2;
            end
            default:
            begin
                cmd.kind = CMD_UNSUP;
            end
        endcase
    end

endmodule

// ===== rtl/cmi_queue.sv =====
// ----------------------------------------------------------------------------
// cmi_queue
// Two-entry command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module cmi_queue import cmi_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output cmd_t    head
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule
